[hw/rtl/mfa_pkg.sv]
// Shared types, operation codes and compare codes for the minifloat ALU.
`timescale 1ns / 1ps
`default_nettype none
package mfa_pkg;
  typedef logic signed [8:0] mant_t;
  typedef logic signed [7:0] expo_t;
  typedef logic [2:0]        op_t;
  typedef logic [1:0]        ord_t;

  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_SUB  = 3'd1;
  localparam op_t OP_MUL  = 3'd2;
  localparam op_t OP_CMPM = 3'd3;
  localparam op_t OP_CMPS = 3'd4;
  localparam op_t OP_ABS  = 3'd5;

  localparam ord_t ORD_EQ = 2'd0;
  localparam ord_t ORD_GT = 2'd1;  // b greater than a
  localparam ord_t ORD_LT = 2'd2;  // b less than a

  // Multiply exponent limits and saturated result
  localparam int MUL_EXP_MAX = 62;
  localparam int MUL_EXP_MIN = -62;
  localparam mant_t SAT_MANT = 9'sh0FF;
  localparam expo_t SAT_EXP  = 8'sd63;

  // Add keeps the larger operand beyond this exponent difference
  localparam int ALIGN_MAX = 9;

  // Last member sits in the lowest bits, matching the tdata layout
  typedef struct packed {
    expo_t b_exponent;
    mant_t b_mantissa;
    expo_t a_exponent;
    mant_t a_mantissa;
    op_t   operation;
  } req_t;
endpackage
`default_nettype wire

[hw/rtl/minifloat_alu.sv]
// Top level of the minifloat ALU: request register, datapath, result register.
// The request register holds each request, and the result register its result.
// Throughput: one request per cycle if unstalled; result register frees on drain.
// All work sits between the request register and the result register.
// Reset (rst_n low, synchronous) clears both valid flags; data is not reset.
`timescale 1ns / 1ps
`default_nettype none
module minifloat_alu (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  // operation[2:0], a_mantissa[11:3], a_exponent[19:12], b_mantissa[28:20],
  // b_exponent[36:29], zero [39:37]
  input  wire  [39:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // result_mantissa[8:0], result_exponent[16:9], order[18:17], zero [23:19]
  output logic [23:0] out_tdata
);
  import mfa_pkg::*;

  logic        req_v_r;
  logic        req_v_nxt;
  req_t        req_r;
  logic        out_v_r;
  logic        out_v_nxt;
  logic [18:0] res_r;
  logic [18:0] res_nxt;
  logic        out_free;
  logic signed [9:0] b_neg;
  logic signed [9:0] b_add;
  mant_t       as_mant;
  expo_t       as_exp;
  mant_t       mu_mant;
  expo_t       mu_exp;
  mant_t       abs_mant;
  logic signed [9:0] a_abs;
  ord_t        ord_m;
  ord_t        ord_s;
  logic signed [9:0] ma;
  logic signed [9:0] mb;

  // Handshake: each stage advances when the next one is free
  assign out_free  = ~out_v_r | out_tready;
  assign in_tready = ~req_v_r | out_free;
  assign req_v_nxt = in_tready ? in_tvalid : req_v_r;
  assign out_v_nxt = out_free ? req_v_r : out_v_r;

  // Subtract negates b at full precision
  assign b_neg = -{req_r.b_mantissa[8], req_r.b_mantissa};
  assign b_add = (req_r.operation == OP_SUB) ? b_neg
               : {req_r.b_mantissa[8], req_r.b_mantissa};

  mfa_addsub u_addsub (
    .a_mant (req_r.a_mantissa),
    .a_exp  (req_r.a_exponent),
    .b_mant (b_add),
    .b_exp  (req_r.b_exponent),
    .r_mant (as_mant),
    .r_exp  (as_exp)
  );

  mfa_mul u_mul (
    .a_mant (req_r.a_mantissa),
    .a_exp  (req_r.a_exponent),
    .b_mant (req_r.b_mantissa),
    .b_exp  (req_r.b_exponent),
    .r_mant (mu_mant),
    .r_exp  (mu_exp)
  );

  // Compares and absolute value
  always_comb begin
    ma = req_r.a_mantissa[8] ? -{1'b1, req_r.a_mantissa}
                             : {1'b0, req_r.a_mantissa};
    mb = req_r.b_mantissa[8] ? -{1'b1, req_r.b_mantissa}
                             : {1'b0, req_r.b_mantissa};
    a_abs    = ma;
    abs_mant = (a_abs > 10'sd255) ? SAT_MANT : a_abs[8:0];

    if (req_r.b_exponent > req_r.a_exponent)      ord_m = ORD_GT;
    else if (req_r.b_exponent < req_r.a_exponent) ord_m = ORD_LT;
    else if (req_r.b_mantissa == req_r.a_mantissa) ord_m = ORD_EQ;
    else if (mb > ma)                              ord_m = ORD_GT;
    else                                           ord_m = ORD_LT;

    ord_s = ORD_EQ;
    if (!req_r.b_mantissa[8] && req_r.a_mantissa[8]) begin
      ord_s = ORD_GT;
    end else if (req_r.b_mantissa[8] && !req_r.a_mantissa[8]) begin
      ord_s = ORD_LT;
    end else if (req_r.b_mantissa > 0 && req_r.a_mantissa > 0) begin
      if (req_r.b_exponent > req_r.a_exponent)       ord_s = ORD_GT;
      else if (req_r.b_exponent < req_r.a_exponent)  ord_s = ORD_LT;
      else if (req_r.b_mantissa > req_r.a_mantissa)  ord_s = ORD_GT;
      else if (req_r.b_mantissa < req_r.a_mantissa)  ord_s = ORD_LT;
    end else if (req_r.b_mantissa[8] && req_r.a_mantissa[8]) begin
      if (req_r.b_exponent < req_r.a_exponent)       ord_s = ORD_GT;
      else if (req_r.b_exponent > req_r.a_exponent)  ord_s = ORD_LT;
      else if (req_r.b_mantissa < req_r.a_mantissa)  ord_s = ORD_GT;
      else if (req_r.b_mantissa > req_r.a_mantissa)  ord_s = ORD_LT;
    end
  end

  // Select the result by operation
  always_comb begin
    case (req_r.operation)
      OP_ADD, OP_SUB: res_nxt = {ORD_EQ, as_exp, as_mant};
      OP_MUL:         res_nxt = {ORD_EQ, mu_exp, mu_mant};
      OP_CMPM:        res_nxt = {ord_m, 17'd0};
      OP_CMPS:        res_nxt = {ord_s, 17'd0};
      OP_ABS:         res_nxt = {ORD_EQ, req_r.a_exponent, abs_mant};
      default:        res_nxt = '0;
    endcase
  end

  // Hold valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      req_v_r <= req_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // Load request and result data
  always_ff @(posedge clk) begin
    if (in_tready) req_r <= in_tdata[36:0];
    if (out_free)  res_r <= res_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {5'd0, res_r};
endmodule
`default_nettype wire

[hw/rtl/mfa_addsub.sv]
// Align, add and renormalize for add and subtract.
`timescale 1ns / 1ps
`default_nettype none
module mfa_addsub (
  input  wire mfa_pkg::mant_t          a_mant,
  input  wire mfa_pkg::expo_t          a_exp,
  input  wire logic signed [9:0]       b_mant,   // b, already negated for subtract
  input  wire mfa_pkg::expo_t          b_exp,
  output mfa_pkg::mant_t               r_mant,
  output mfa_pkg::expo_t               r_exp
);
  import mfa_pkg::*;

  logic signed [9:0]  a_ext;
  logic signed [9:0]  l_mant;
  logic signed [9:0]  s_mant;
  logic signed [7:0]  l_exp;
  logic signed [7:0]  s_exp;
  logic signed [8:0]  diff;
  logic signed [9:0]  aligned;
  logic signed [10:0] sum;
  logic signed [10:0] sum_r;
  logic signed [15:0] trial;
  logic [1:0]         rsh;
  logic [2:0]         lsh;
  logic               pos;
  logic signed [15:0] norm;

  assign a_ext = {a_mant[8], a_mant};

  always_comb begin
    // Pick the operand with the larger exponent, a on a tie
    if (a_exp >= b_exp) begin
      l_mant = a_ext;  l_exp = a_exp;
      s_mant = b_mant; s_exp = b_exp;
    end else begin
      l_mant = b_mant; l_exp = b_exp;
      s_mant = a_ext;  s_exp = a_exp;
    end
    diff    = {l_exp[7], l_exp} - {s_exp[7], s_exp};
    aligned = s_mant >>> diff[3:0];
    sum     = {l_mant[9], l_mant} + {aligned[9], aligned};
    pos     = ~sum[10];

    // Right shift on overflow past 255; a negative sum of -511 needs two halvings
    if (pos ? (sum >= 11'sd512) : (sum <= -11'sd511))
      rsh = 2'd2;
    else if (pos ? (sum >= 11'sd256) : (sum <= -11'sd256))
      rsh = 2'd1;
    else
      rsh = 2'd0;
    sum_r = sum >>> rsh;

    // Smallest left shift that reaches magnitude 128
    lsh = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      trial = {{5{sum_r[10]}}, sum_r} <<< k;
      if (pos ? (trial >= 16'sd128) : (trial <= -16'sd128))
        lsh = 3'(k);
    end
    norm = {{5{sum_r[10]}}, sum_r} <<< lsh;

    // Select the result
    if (a_mant == '0) begin
      r_mant = b_mant[8:0];
      r_exp  = b_exp;
    end else if (b_mant == '0) begin
      r_mant = a_mant;
      r_exp  = a_exp;
    end else if (diff > 9'(ALIGN_MAX)) begin
      r_mant = l_mant[8:0];
      r_exp  = l_exp;
    end else if (sum == '0) begin
      r_mant = '0;
      r_exp  = '0;
    end else begin
      r_mant = norm[8:0];
      r_exp  = l_exp + {6'd0, rsh} - {5'd0, lsh};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/mfa_mul.sv]
// 9x9 multiply with normalize, round and exponent limits.
`timescale 1ns / 1ps
`default_nettype none
module mfa_mul (
  input  wire mfa_pkg::mant_t a_mant,
  input  wire mfa_pkg::expo_t a_exp,
  input  wire mfa_pkg::mant_t b_mant,
  input  wire mfa_pkg::expo_t b_exp,
  output mfa_pkg::mant_t      r_mant,
  output mfa_pkg::expo_t      r_exp
);
  import mfa_pkg::*;

  logic signed [8:0]  esum;
  logic signed [17:0] prod;
  logic signed [19:0] q0;
  logic signed [19:0] q1;
  logic signed [19:0] q2;
  logic signed [19:0] hi0;
  logic signed [19:0] hi2;
  logic signed [19:0] half_v;
  logic               pos;
  logic               dbl;
  logic               halve;

  always_comb begin
    esum = {a_exp[7], a_exp} + {b_exp[7], b_exp};
    prod = a_mant * b_mant;
    q0   = {{2{prod[17]}}, prod};
    pos  = (q0 > 20'sd0);

    // Normalize up by one when below 128
    hi0 = q0 >>> 8;
    dbl = pos ? (hi0 < 20'sd128) : (hi0 > -20'sd128);
    q1  = dbl ? (q0 <<< 1) : q0;

    // Round on the dropped bit
    q2  = q1 + (q1[7] ? 20'sd256 : 20'sd0);
    hi2 = q2 >>> 8;
    halve  = pos ? (hi2 >= 20'sd256) : (hi2 <= -20'sd256);
    half_v = q2 >>> 9;

    if (a_mant == '0 || b_mant == '0 || esum < 9'(MUL_EXP_MIN)) begin
      r_mant = '0;
      r_exp  = '0;
    end else if (esum > 9'(MUL_EXP_MAX)) begin
      r_mant = SAT_MANT;
      r_exp  = SAT_EXP;
    end else begin
      r_mant = halve ? half_v[8:0] : hi2[8:0];
      r_exp  = esum[7:0] - {7'd0, dbl} + {7'd0, halve};
    end
  end
endmodule
`default_nettype wire

[hw/rtl/minifloat_alu_chk.sv]
// Port-level checker for the minifloat ALU and its bind.
`timescale 1ns / 1ps
`default_nettype none
module minifloat_alu_chk (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire [39:0] in_tdata,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [23:0] out_tdata
);
  // Stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // Reset empties the result stage
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Unequal compare results carry no mantissa or exponent
  a_cmp_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[18:17] != 2'd0 |-> out_tdata[16:0] == 17'd0)
    else $error("compare result with nonzero number");

  // Stalled request holds its data
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata))
    else $error("request changed while stalled");

  // Empty result stage always takes a request
  a_in_ready: assert property (@(posedge clk) !out_tvalid |-> in_tready)
    else $error("input blocked with empty result stage");
endmodule

bind minifloat_alu minifloat_alu_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
`default_nettype wire
